// ----- rtl/r2y_pkg.sv -----
// shared constants, coefficient values and control types for the rgb to yuv 4:2:0 converter
// used by every converter module but the generic line ram; depends on nothing
package r2y_pkg;

	// frame geometry limits and register widths
	localparam int MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_W = 13;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W = $clog2(LINE_DEPTH);
	localparam int PIX_W = 8;
	localparam int BLK_W = 22;

	// configuration register indexes
	localparam int CIDX_W = 1;
	localparam logic [CIDX_W-1:0] REG_LINE_WIDTH = 1'b0;
	localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd1920;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
	localparam logic [CFG_W-1:0] WIDTH_LIMIT = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_LIMIT = CFG_W'(MAX_HEIGHT);

	// fixed point coefficients, round(c * 2^frac) with c in thousandths
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W = COEF_FRAC_BITS;
	localparam longint FX_ONE = 64'd1 << COEF_FRAC_BITS;
	localparam logic [COEF_W-1:0] COEF_Y_R = COEF_W'((299 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_Y_G = COEF_W'((587 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_Y_B = COEF_W'((114 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_U_R = COEF_W'((147 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_U_G = COEF_W'((289 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_U_B = COEF_W'((436 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_V_R = COEF_W'((615 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_V_G = COEF_W'((515 * FX_ONE + 500) / 1000);
	localparam logic [COEF_W-1:0] COEF_V_B = COEF_W'((100 * FX_ONE + 500) / 1000);

	// weighted sum and rounded part widths
	localparam int SUM_W = COEF_FRAC_BITS + PIX_W + 2;
	localparam int MAG_W = SUM_W - COEF_FRAC_BITS;
	localparam logic [SUM_W-1:0] FX_HALF = SUM_W'(64'd1 << (COEF_FRAC_BITS - 1));
	localparam int UP_W = 8;
	localparam int VP_W = 9;
	localparam int UPAIR_W = UP_W + 1;
	localparam int VPAIR_W = VP_W + 1;
	localparam int UTOT_W = UPAIR_W + 1;
	localparam int VTOT_W = VPAIR_W + 1;

	// per pixel position information, fixed at acceptance
	typedef struct packed {
		logic col_odd;
		logic row_odd;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0] blk_idx;
		logic fend;
	} pix_ctrl_t;

	// stage load strobes of the pixel pipeline
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
	} pipe_en_t;

endpackage

// ----- rtl/rgba_to_yuv420_converter.sv -----
// top level of the rgb to yuv 4:2:0 converter: handshakes, stage valid bits, checks
// depends on r2y_pkg, r2y_position, r2y_color_math, r2y_chroma

// Takes one rgb pixel per clock while in_ready is high, in raster order, and returns one request per pixel: its luma,
// plus u, v and the chroma plane index when the pixel closes a 2x2 block (odd row, odd
// column). Sustained rate is one pixel per cycle while the output is not stalled; a pixel passes
// through the input register, weighted sums, rounding, pair sum with line store read and output
// register, and every stage moves on its own so bubbles close up behind a stalled output.
// Chroma pair sums of even rows live in a 2048 x 19 bit line store with one write and one
// registered read port; the read for a pixel is issued one stage ahead of the write stage
// and same-address collisions are forwarded. The store needs no clearing after reset: every
// entry is written on an even row before an odd row reads it. Width and height are taken
// even and clamped to 2..4096; write them only while the block is idle.
module rgba_to_yuv420_converter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [r2y_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [r2y_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [r2y_pkg::PIX_W-1:0]   red,
	input  logic [r2y_pkg::PIX_W-1:0]   green,
	input  logic [r2y_pkg::PIX_W-1:0]   blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [r2y_pkg::PIX_W-1:0]   luma,
	output logic                        chroma_valid,
	output logic [r2y_pkg::PIX_W-1:0]   blue_difference,
	output logic [r2y_pkg::PIX_W-1:0]   red_difference,
	output logic [r2y_pkg::BLK_W-1:0]   chroma_index,
	output logic                        frame_end
);

	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic               vld_s4;
	logic               go_s1;
	logic               go_s2;
	logic               go_s3;
	logic               go_s4;
	logic               go_out;
	logic               accept;
	r2y_pkg::pipe_en_t  en;
	r2y_pkg::pix_ctrl_t pix_ctrl;
	r2y_pkg::pix_ctrl_t ctrl_s3;
	logic [r2y_pkg::PIX_W-1:0] luma_s3;
	logic [r2y_pkg::UP_W-1:0]  u_part_s3;
	logic [r2y_pkg::VP_W-1:0]  v_part_s3;

	// a stage can load when it is empty or its content moves on
	always_comb begin
		go_out = !out_valid || out_ready;
		go_s4 = !vld_s4 || go_out;
		go_s3 = !vld_s3 || go_s4;
		go_s2 = !vld_s2 || go_s3;
		go_s1 = !vld_s1 || go_s2;
		in_ready = go_s1;
		cfg_ready = 1'b1;
		accept = in_valid && go_s1;
		en.ld_s1 = accept;
		en.ld_s2 = vld_s1 && go_s2;
		en.ld_s3 = vld_s2 && go_s3;
		en.ld_s4 = vld_s3 && go_s4;
		en.ld_out = vld_s4 && go_out;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1 <= en.ld_s1 || (vld_s1 && !en.ld_s2);
			vld_s2 <= en.ld_s2 || (vld_s2 && !en.ld_s3);
			vld_s3 <= en.ld_s3 || (vld_s3 && !en.ld_s4);
			vld_s4 <= en.ld_s4 || (vld_s4 && !en.ld_out);
			out_valid <= en.ld_out || (out_valid && !out_ready);
		end
	end

	// position counters and configuration
	r2y_position u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.ctrl      (pix_ctrl)
	);

	// color arithmetic
	r2y_color_math u_color_math (
		.clk       (clk),
		.en        (en),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.ctrl_in   (pix_ctrl),
		.ctrl_s3   (ctrl_s3),
		.luma_s3   (luma_s3),
		.u_part_s3 (u_part_s3),
		.v_part_s3 (v_part_s3)
	);

	// subsampling and output
	r2y_chroma u_chroma (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.ctrl_s3         (ctrl_s3),
		.luma_s3         (luma_s3),
		.u_part_s3       (u_part_s3),
		.v_part_s3       (v_part_s3),
		.luma            (luma),
		.chroma_valid    (chroma_valid),
		.blue_difference (blue_difference),
		.red_difference  (red_difference),
		.chroma_index    (chroma_index),
		.frame_end       (frame_end)
	);

	// an empty output register lets the whole pipeline take a pixel
	assert property (@(posedge clk) disable iff (!arst_n) !out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// the last pixel of a frame returns the position to the frame origin
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix_ctrl.fend |=> pix_ctrl.slot == '0 && !pix_ctrl.col_odd
			&& !pix_ctrl.row_odd && pix_ctrl.blk_idx == '0)
		else $error("position not cleared after frame end");

	// chroma fields read zero when no block completes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |-> blue_difference == '0 && red_difference == '0
			&& chroma_index == '0)
		else $error("chroma fields set without a completed block");

endmodule

// ----- rtl/r2y_line_ram.sv -----
// generic single write port, single read port ram with registered read data
// a read and a write of the same address in one cycle returns the new data; no dependencies
module r2y_line_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 19,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port with write-first bypass
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

// ----- rtl/r2y_position.sv -----
// configuration registers and raster position counters of the converter
// depends on r2y_pkg
module r2y_position (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr,
	input  logic [r2y_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [r2y_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        accept,
	output r2y_pkg::pix_ctrl_t          ctrl
);

	logic [r2y_pkg::CFG_W-1:0] line_width_q;
	logic [r2y_pkg::CFG_W-1:0] frame_height_q;
	logic [r2y_pkg::COL_W-1:0] col_q;
	logic [r2y_pkg::ROW_W-1:0] row_q;
	logic [r2y_pkg::BLK_W-1:0] blk_q;
	logic [r2y_pkg::CFG_W-1:0] w_eff;
	logic [r2y_pkg::CFG_W-1:0] h_eff;
	logic [r2y_pkg::COL_W:0]   col_inc;
	logic [r2y_pkg::ROW_W:0]   row_inc;
	logic                      last_col;
	logic                      last_row;
	logic                      chroma;

	// clamp to 2..limit and round down to even
	function automatic logic [r2y_pkg::CFG_W-1:0] eff_size(
		input logic [r2y_pkg::CFG_W-1:0] v,
		input logic [r2y_pkg::CFG_W-1:0] limit
	);
		logic [r2y_pkg::CFG_W-1:0] c;
		c = v;
		if (c < r2y_pkg::CFG_W'(2)) c = r2y_pkg::CFG_W'(2);
		if (c > limit) c = limit;
		return {c[r2y_pkg::CFG_W-1:1], 1'b0};
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= r2y_pkg::LINE_WIDTH_RST;
			frame_height_q <= r2y_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				r2y_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
				r2y_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// wrap decisions for the current pixel
	always_comb begin
		w_eff = eff_size(line_width_q, r2y_pkg::WIDTH_LIMIT);
		h_eff = eff_size(frame_height_q, r2y_pkg::HEIGHT_LIMIT);
		col_inc = {1'b0, col_q} + (r2y_pkg::COL_W+1)'(1);
		row_inc = {1'b0, row_q} + (r2y_pkg::ROW_W+1)'(1);
		last_col = r2y_pkg::CFG_W'(col_inc) >= w_eff;
		last_row = r2y_pkg::CFG_W'(row_inc) >= h_eff;
		chroma = col_q[0] & row_q[0];
	end

	// control word handed down the pipeline
	always_comb begin
		ctrl.col_odd = col_q[0];
		ctrl.row_odd = row_q[0];
		ctrl.slot = col_q[r2y_pkg::COL_W-1:1];
		ctrl.blk_idx = blk_q;
		ctrl.fend = last_col & last_row;
	end

	// position and block counters advance per accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			blk_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[r2y_pkg::ROW_W-1:0];
				end
			end else begin
				col_q <= col_inc[r2y_pkg::COL_W-1:0];
			end
			if (last_col && last_row) begin
				blk_q <= '0;
			end else if (chroma) begin
				blk_q <= blk_q + r2y_pkg::BLK_W'(1);
			end
		end
	end

endmodule

// ----- rtl/r2y_color_math.sv -----
// front stages of the pixel pipeline: input register, weighted sums, rounding
// produces luma and the signed u and v parts per pixel; depends on r2y_pkg
module r2y_color_math (
	input  logic                       clk,
	input  r2y_pkg::pipe_en_t          en,
	input  logic [r2y_pkg::PIX_W-1:0]  red,
	input  logic [r2y_pkg::PIX_W-1:0]  green,
	input  logic [r2y_pkg::PIX_W-1:0]  blue,
	input  r2y_pkg::pix_ctrl_t         ctrl_in,
	output r2y_pkg::pix_ctrl_t         ctrl_s3,
	output logic [r2y_pkg::PIX_W-1:0]  luma_s3,
	output logic [r2y_pkg::UP_W-1:0]   u_part_s3,
	output logic [r2y_pkg::VP_W-1:0]   v_part_s3
);

	logic [r2y_pkg::PIX_W-1:0] red_s1;
	logic [r2y_pkg::PIX_W-1:0] green_s1;
	logic [r2y_pkg::PIX_W-1:0] blue_s1;
	r2y_pkg::pix_ctrl_t        ctrl_s1;
	r2y_pkg::pix_ctrl_t        ctrl_s2;
	logic [r2y_pkg::SUM_W-1:0] y_sum_s2;
	logic [r2y_pkg::SUM_W-1:0] u_pos_s2;
	logic [r2y_pkg::SUM_W-1:0] u_neg_s2;
	logic [r2y_pkg::SUM_W-1:0] v_pos_s2;
	logic [r2y_pkg::SUM_W-1:0] v_neg_s2;
	logic [r2y_pkg::SUM_W-1:0] y_rnd;
	logic [r2y_pkg::MAG_W-1:0] y_int;
	logic [r2y_pkg::MAG_W:0]   u_rnd;
	logic [r2y_pkg::MAG_W:0]   v_rnd;

	// constant times pixel component
	function automatic logic [r2y_pkg::SUM_W-1:0] cmul(
		input logic [r2y_pkg::COEF_W-1:0] c,
		input logic [r2y_pkg::PIX_W-1:0]  p
	);
		return r2y_pkg::SUM_W'(c) * r2y_pkg::SUM_W'(p);
	endfunction

	// round (pos - neg) / 2^frac half away from zero, two's complement result
	function automatic logic [r2y_pkg::MAG_W:0] round_signed(
		input logic [r2y_pkg::SUM_W-1:0] pos,
		input logic [r2y_pkg::SUM_W-1:0] neg
	);
		logic [r2y_pkg::SUM_W-1:0] d;
		logic [r2y_pkg::SUM_W-1:0] r;
		logic [r2y_pkg::MAG_W:0]   m;
		if (pos >= neg) d = pos - neg;
		else d = neg - pos;
		r = d + r2y_pkg::FX_HALF;
		m = {1'b0, r[r2y_pkg::SUM_W-1:r2y_pkg::COEF_FRAC_BITS]};
		if (pos >= neg) return m;
		return -m;
	endfunction

	// input register
	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			red_s1 <= red;
			green_s1 <= green;
			blue_s1 <= blue;
			ctrl_s1 <= ctrl_in;
		end
	end

	// weighted sums, split into positive and negative terms
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			ctrl_s2 <= ctrl_s1;
			y_sum_s2 <= cmul(r2y_pkg::COEF_Y_R, red_s1) + cmul(r2y_pkg::COEF_Y_G, green_s1)
				+ cmul(r2y_pkg::COEF_Y_B, blue_s1);
			u_pos_s2 <= cmul(r2y_pkg::COEF_U_B, blue_s1);
			u_neg_s2 <= cmul(r2y_pkg::COEF_U_R, red_s1) + cmul(r2y_pkg::COEF_U_G, green_s1);
			v_pos_s2 <= cmul(r2y_pkg::COEF_V_R, red_s1);
			v_neg_s2 <= cmul(r2y_pkg::COEF_V_G, green_s1) + cmul(r2y_pkg::COEF_V_B, blue_s1);
		end
	end

	// rounding
	always_comb begin
		y_rnd = y_sum_s2 + r2y_pkg::FX_HALF;
		y_int = y_rnd[r2y_pkg::SUM_W-1:r2y_pkg::COEF_FRAC_BITS];
		u_rnd = round_signed(u_pos_s2, u_neg_s2);
		v_rnd = round_signed(v_pos_s2, v_neg_s2);
	end

	// rounded results, luma saturated at full scale
	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			ctrl_s3 <= ctrl_s2;
			if (y_int > r2y_pkg::MAG_W'(255)) begin
				luma_s3 <= '1;
			end else begin
				luma_s3 <= y_int[r2y_pkg::PIX_W-1:0];
			end
			u_part_s3 <= u_rnd[r2y_pkg::UP_W-1:0];
			v_part_s3 <= v_rnd[r2y_pkg::VP_W-1:0];
		end
	end

endmodule

// ----- rtl/r2y_chroma.sv -----
// back stages: pair sums with the held even column, line store read-modify-write,
// 2x2 chroma totals and the output register; depends on r2y_pkg and r2y_line_ram
module r2y_chroma (
	input  logic                       clk,
	input  logic                       arst_n,
	input  r2y_pkg::pipe_en_t          en,
	input  r2y_pkg::pix_ctrl_t         ctrl_s3,
	input  logic [r2y_pkg::PIX_W-1:0]  luma_s3,
	input  logic [r2y_pkg::UP_W-1:0]   u_part_s3,
	input  logic [r2y_pkg::VP_W-1:0]   v_part_s3,
	output logic [r2y_pkg::PIX_W-1:0]  luma,
	output logic                       chroma_valid,
	output logic [r2y_pkg::PIX_W-1:0]  blue_difference,
	output logic [r2y_pkg::PIX_W-1:0]  red_difference,
	output logic [r2y_pkg::BLK_W-1:0]  chroma_index,
	output logic                       frame_end
);

	localparam int LINE_W = r2y_pkg::UPAIR_W + r2y_pkg::VPAIR_W;

	logic [r2y_pkg::UP_W-1:0]     held_u_q;
	logic [r2y_pkg::VP_W-1:0]     held_v_q;
	r2y_pkg::pix_ctrl_t           ctrl_s4;
	logic [r2y_pkg::PIX_W-1:0]    luma_s4;
	logic [r2y_pkg::UPAIR_W-1:0]  u_pair_s4;
	logic [r2y_pkg::VPAIR_W-1:0]  v_pair_s4;
	logic [r2y_pkg::UPAIR_W-1:0]  u_pair;
	logic [r2y_pkg::VPAIR_W-1:0]  v_pair;
	logic                         ram_we;
	logic [LINE_W-1:0]            ram_rdata;
	logic signed [r2y_pkg::UTOT_W-1:0] u_tot;
	logic signed [r2y_pkg::VTOT_W-1:0] v_tot;
	logic                         chroma;

	// clamp(128 + floor(total / 4), 0, 255)
	function automatic logic [r2y_pkg::PIX_W-1:0] chroma_value(
		input logic signed [r2y_pkg::VTOT_W-1:0] total
	);
		logic signed [r2y_pkg::VTOT_W:0] t;
		t = (r2y_pkg::VTOT_W+1)'(total >>> 2) + (r2y_pkg::VTOT_W+1)'(128);
		if (t < 0) return '0;
		if (t > 255) return '1;
		return t[r2y_pkg::PIX_W-1:0];
	endfunction

	// pair sums with the held even column parts
	always_comb begin
		u_pair = r2y_pkg::UPAIR_W'($signed(held_u_q)) + r2y_pkg::UPAIR_W'($signed(u_part_s3));
		v_pair = r2y_pkg::VPAIR_W'($signed(held_v_q)) + r2y_pkg::VPAIR_W'($signed(v_part_s3));
	end

	// even column parts are held for the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_u_q <= '0;
			held_v_q <= '0;
		end else if (en.ld_s4 && !ctrl_s3.col_odd) begin
			held_u_q <= u_part_s3;
			held_v_q <= v_part_s3;
		end
	end

	// pair stage; the line store read for this pixel is issued on the same edge
	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			ctrl_s4 <= ctrl_s3;
			luma_s4 <= luma_s3;
			u_pair_s4 <= u_pair;
			v_pair_s4 <= v_pair;
		end
	end

	// line store of even row pair sums, u in the upper bits
	assign ram_we = en.ld_out && ctrl_s4.col_odd && !ctrl_s4.row_odd;

	r2y_line_ram #(
		.DEPTH (r2y_pkg::LINE_DEPTH),
		.WIDTH (LINE_W)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctrl_s4.slot),
		.wdata ({u_pair_s4, v_pair_s4}),
		.re    (en.ld_s4),
		.raddr (ctrl_s3.slot),
		.rdata (ram_rdata)
	);

	// 2x2 totals from stored and current pair sums
	always_comb begin
		u_tot = r2y_pkg::UTOT_W'($signed(ram_rdata[LINE_W-1:r2y_pkg::VPAIR_W]))
			+ r2y_pkg::UTOT_W'($signed(u_pair_s4));
		v_tot = r2y_pkg::VTOT_W'($signed(ram_rdata[r2y_pkg::VPAIR_W-1:0]))
			+ r2y_pkg::VTOT_W'($signed(v_pair_s4));
		chroma = ctrl_s4.col_odd & ctrl_s4.row_odd;
	end

	// output register
	always_ff @(posedge clk) begin
		if (en.ld_out) begin
			luma <= luma_s4;
			chroma_valid <= chroma;
			frame_end <= ctrl_s4.fend;
			if (chroma) begin
				blue_difference <= chroma_value(r2y_pkg::VTOT_W'(u_tot));
				red_difference <= chroma_value(v_tot);
				chroma_index <= ctrl_s4.blk_idx;
			end else begin
				blue_difference <= '0;
				red_difference <= '0;
				chroma_index <= '0;
			end
		end
	end

endmodule

// ----- test/rgba_to_yuv420_converter_test.sv -----
// self-checking testbench for rgba_to_yuv420_converter: streams pixels, predicts every result
// with its own bit-accurate model of the 4:2:0 conversion; depends on r2y_pkg and the rtl
`timescale 1ns / 1ps

module rgba_to_yuv420_converter_test;

	import r2y_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 30;
	localparam int LINE_SLOTS = MAX_WIDTH / 2;

	// fixed point weights, round(c * 2^frac) with c in thousandths
	localparam int FRAC = COEF_FRAC_BITS;
	localparam longint UNIT = longint'(1) << FRAC;
	localparam longint HALF = UNIT >> 1;
	localparam longint KY_R = (299 * UNIT + 500) / 1000;
	localparam longint KY_G = (587 * UNIT + 500) / 1000;
	localparam longint KY_B = (114 * UNIT + 500) / 1000;
	localparam longint KU_R = (147 * UNIT + 500) / 1000;
	localparam longint KU_G = (289 * UNIT + 500) / 1000;
	localparam longint KU_B = (436 * UNIT + 500) / 1000;
	localparam longint KV_R = (615 * UNIT + 500) / 1000;
	localparam longint KV_G = (515 * UNIT + 500) / 1000;
	localparam longint KV_B = (100 * UNIT + 500) / 1000;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic chroma_valid;
		logic [PIX_W-1:0] blue_difference;
		logic [PIX_W-1:0] red_difference;
		logic [BLK_W-1:0] chroma_index;
		logic frame_end;
	} yuv_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index = REG_LINE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] red = '0;
	logic [PIX_W-1:0] green = '0;
	logic [PIX_W-1:0] blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] luma;
	logic chroma_valid;
	logic [PIX_W-1:0] blue_difference;
	logic [PIX_W-1:0] red_difference;
	logic [BLK_W-1:0] chroma_index;
	logic frame_end;

	rgba_to_yuv420_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.luma(luma),
		.chroma_valid(chroma_valid),
		.blue_difference(blue_difference),
		.red_difference(red_difference),
		.chroma_index(chroma_index),
		.frame_end(frame_end)
	);

	// converter state as the model tracks it
	logic [CFG_W-1:0] width_reg = 13'd1920;
	logic [CFG_W-1:0] height_reg = 13'd1080;
	int col_pos = 0;
	int row_pos = 0;
	int held_u = 0;
	int held_v = 0;
	int u_line [LINE_SLOTS];
	int v_line [LINE_SLOTS];
	bit slot_written [LINE_SLOTS];
	logic [BLK_W-1:0] block_count = '0;

	rgb_pixel_t pending_pixels[$];
	yuv_result_t expected_yuv[$];
	rgb_pixel_t held_pixel;
	bit pix_busy = 1'b0;
	int pix_gap = 0;
	int out_stall = 0;
	bit pix_idle_on = 1'b0;
	bit out_idle_on = 1'b0;
	int mismatch_count = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// size register as the block sees it: clamped to 2..limit, then made even
	function automatic int clamp_even(logic [CFG_W-1:0] raw, int limit);
		int v;
		v = raw;
		if (v < 2) v = 2;
		if (v > limit) v = limit;
		return v & ~1;
	endfunction

	// difference of two non-negative weighted sums, rounded half away from zero
	function automatic int round_half_away(longint plus, longint minus);
		if (plus >= minus) return int'((plus - minus + HALF) >>> FRAC);
		return -int'((minus - plus + HALF) >>> FRAC);
	endfunction

	// 128 + floor(total / 4), clamped to a byte
	function automatic logic [PIX_W-1:0] chroma_from_total(int total);
		int level;
		level = 128 + (total >>> 2);
		if (level < 0) level = 0;
		else if (level > 255) level = 255;
		return level[PIX_W-1:0];
	endfunction

	// advance the converter state by one pixel and return its result
	function automatic yuv_result_t convert_pixel(rgb_pixel_t px);
		yuv_result_t res;
		longint r, g, b, y;
		int u_part, v_part, u_pair, v_pair, wd, ht, slot;
		r = px.red;
		g = px.green;
		b = px.blue;
		wd = clamp_even(width_reg, MAX_WIDTH);
		ht = clamp_even(height_reg, MAX_HEIGHT);
		res = '0;
		y = (KY_R * r + KY_G * g + KY_B * b + HALF) >>> FRAC;
		if (y > 255) y = 255;
		res.luma = y[PIX_W-1:0];
		u_part = round_half_away(KU_B * b, KU_R * r + KU_G * g);
		v_part = round_half_away(KV_R * r, KV_G * g + KV_B * b);

		// even column holds, odd column pairs up; even rows store, odd rows finish the block
		if ((col_pos & 1) == 0) begin
			held_u = u_part;
			held_v = v_part;
		end else begin
			u_pair = held_u + u_part;
			v_pair = held_v + v_part;
			slot = (col_pos >> 1) % LINE_SLOTS;
			if ((row_pos & 1) == 0) begin
				u_line[slot] = u_pair;
				v_line[slot] = v_pair;
				slot_written[slot] = 1'b1;
			end else begin
				res.chroma_valid = 1'b1;
				res.blue_difference = chroma_from_total(u_line[slot] + u_pair);
				res.red_difference = chroma_from_total(v_line[slot] + v_pair);
				res.chroma_index = block_count;
				block_count = block_count + 1'b1;
			end
		end

		// raster position, a position past a shrunk size wraps like the last one
		if (col_pos + 1 >= wd) begin
			col_pos = 0;
			if (row_pos + 1 >= ht) begin
				row_pos = 0;
				block_count = '0;
				res.frame_end = 1'b1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		return res;
	endfunction

	// a new width must not make an odd row read a line store entry never written
	function automatic bit width_write_safe(logic [CFG_W-1:0] raw);
		int wd, last;
		wd = clamp_even(raw, MAX_WIDTH);
		if ((row_pos & 1) == 0) return 1'b1;
		last = (col_pos + 1 >= wd) ? col_pos : wd - 1;
		for (int c = col_pos; c <= last; c++) begin
			if ((c & 1) && !slot_written[(c >> 1) % LINE_SLOTS]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [PIX_W-1:0] draw_component();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly small even sizes, now and then odd, tiny or oversized values
	function automatic logic [CFG_W-1:0] draw_size();
		case ($urandom_range(0, 19))
			0: return CFG_W'($urandom_range(0, 1));
			1: return CFG_W'($urandom_range(MAX_WIDTH + 1, 8191));
			2: return CFG_W'(MAX_WIDTH);
			3, 4: return CFG_W'(2 * $urandom_range(1, 8) + 1);
			5: return CFG_W'($urandom_range(18, 64));
			default: return CFG_W'(2 * $urandom_range(1, 8));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input longint got, input longint want);
		if (got != want) report_mismatch($sformatf("%s got %0d, wanted %0d", name, got, want));
	endtask

	task automatic queue_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		rgb_pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		pending_pixels.push_back(px);
	endtask

	task automatic queue_random_pixels(input int count);
		repeat (count) queue_pixel(draw_component(), draw_component(), draw_component());
	endtask

	// wait until every pixel is in and every result is out, then let the pipe drain
	task automatic wait_idle();
		while (pending_pixels.size() != 0 || pix_busy || expected_yuv.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write request; the model takes the value when it is accepted
	task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		if (idx == REG_LINE_WIDTH && !width_write_safe(value)) value = width_reg;
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LINE_WIDTH: width_reg = value;
			REG_FRAME_HEIGHT: height_reg = value;
			default: ;
		endcase
	endtask

	// pixel driver: one request per queued pixel, random gap before each
	always @(posedge clk) begin : drive_pixels
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_yuv.push_back(convert_pixel(held_pixel));
				pix_busy = 1'b0;
				pix_gap = pix_idle_on ? $urandom_range(0, 4) : 0;
			end
			if (!pix_busy) begin
				if (pix_gap != 0) begin
					pix_gap--;
				end else if (pending_pixels.size() != 0) begin
					held_pixel = pending_pixels.pop_front();
					pix_busy = 1'b1;
					red <= held_pixel.red;
					green <= held_pixel.green;
					blue <= held_pixel.blue;
				end
			end
			in_valid <= pix_busy;
		end
	end

	// result monitor: compare each request with the oldest prediction, random stalls
	always @(posedge clk) begin : check_results
		yuv_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_yuv.size() == 0) begin
					report_mismatch("result with no pixel waiting for it");
				end else begin
					want = expected_yuv.pop_front();
					compare_field("luma", luma, want.luma);
					compare_field("chroma_valid", chroma_valid, want.chroma_valid);
					compare_field("blue_difference", blue_difference, want.blue_difference);
					compare_field("red_difference", red_difference, want.red_difference);
					compare_field("chroma_index", chroma_index, want.chroma_index);
					compare_field("frame_end", frame_end, want.frame_end);
				end
				out_stall = out_idle_on ? $urandom_range(0, 4) : 0;
			end
			if (out_stall != 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rgba_to_yuv420_converter_test NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int random_sent;
		int count;
		random_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame from sizes below the minimum: both clamp up to 2
		write_register(REG_LINE_WIDTH, 13'd1);
		write_register(REG_FRAME_HEIGHT, 13'd0);
		repeat (4) queue_pixel(8'd255, 8'd0, 8'd0);
		repeat (4) queue_pixel(8'd0, 8'd255, 8'd255);
		wait_idle();

		// oversized sizes clamp to the limit; start a wide row with color extremes
		write_register(REG_LINE_WIDTH, 13'd8191);
		write_register(REG_FRAME_HEIGHT, 13'd8191);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd255, 8'd0, 8'd0);
		queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd0, 8'd0, 8'd255);
		queue_pixel(8'd255, 8'd255, 8'd0);
		queue_pixel(8'd0, 8'd255, 8'd255);
		queue_pixel(8'd255, 8'd0, 8'd255);
		queue_pixel(8'd128, 8'd128, 8'd128);
		queue_pixel(8'd1, 8'd2, 8'd3);
		wait_idle();

		// width shrunk mid row: the column past the new end wraps to the next row
		write_register(REG_LINE_WIDTH, 13'd4);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd0);
		queue_pixel(8'd0, 8'd0, 8'd255);
		queue_pixel(8'd255, 8'd0, 8'd255);
		queue_pixel(8'd0, 8'd255, 8'd0);
		wait_idle();

		// height shrunk below the current row: frame ends at the end of this row
		write_register(REG_FRAME_HEIGHT, 13'd2);
		queue_random_pixels(4);
		wait_idle();

		// random phases, mostly small frames, sizes changed wherever the stream stands
		while (random_sent < RANDOM_ITEMS) begin
			pix_idle_on = $urandom_range(0, 3) != 0;
			out_idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 2) != 0) write_register(REG_LINE_WIDTH, draw_size());
			if ($urandom_range(0, 2) != 0) write_register(REG_FRAME_HEIGHT, draw_size());
			count = $urandom_range(1, 100);
			queue_random_pixels(count);
			random_sent += count;
			wait_idle();
		end

		if (mismatch_count == 0) begin
			$display("rgba_to_yuv420_converter_test OK");
		end else begin
			$display("rgba_to_yuv420_converter_test NOT OK");
		end
		$finish;
	end

endmodule
